### hdl/rigid_transform_chain_macros.svh
// assertion macros for the rigid transform chain
`ifndef RIGID_TRANSFORM_CHAIN_MACROS_SVH
`define RIGID_TRANSFORM_CHAIN_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define RTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define RTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RTC_ASSERT(lbl, prop, msg)
`define RTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/rtc_pkg.sv
package rtc_pkg;

  localparam int MAX_STAGES = 8;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int COEF_NUM   = 12;
  localparam int T_BASE     = 9;
  localparam int SLOT_W     = 4;
  localparam int STAGE_W    = 3;
  localparam int CFG_W      = 4;
  localparam int IDX_W      = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int ACC_W      = PROD_W - FRAC_BITS + 4;
  localparam int CNT_W      = 4;
  localparam int LAST_STEP  = 9;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FWD   = 2'd1,
    OP_INV   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // point hand-off between neighboring cells
  typedef struct packed {
    logic             valid;
    logic             dir;
    logic             flag;
    coord_t [2:0]     pt;
  } link_t;

  typedef struct packed {
    coord_t val;
    logic   ovf;
  } sat_t;

  localparam acc_t ACC_MAX = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam acc_t ACC_MIN = ~ACC_MAX;

  // saturate a wide sum to a coordinate
  function automatic sat_t sat_coord(acc_t v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[COORD_W-1:0];
    if (v > ACC_MAX) begin
      r.ovf = 1'b1;
      r.val = ACC_MAX[COORD_W-1:0];
    end else if (v < ACC_MIN) begin
      r.ovf = 1'b1;
      r.val = ACC_MIN[COORD_W-1:0];
    end
    return r;
  endfunction

  // column of a matrix step
  function automatic logic [1:0] col_of(logic [CNT_W-1:0] s);
    logic [1:0] c;
    case (s)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      4'd2, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

  // row of a matrix step
  function automatic logic [1:0] row_of(logic [CNT_W-1:0] s);
    logic [1:0] r;
    case (s)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // coefficient index of the transposed matrix
  function automatic logic [SLOT_W-1:0] tr_idx(logic [CNT_W-1:0] s);
    logic [SLOT_W-1:0] t;
    case (s)
      4'd0:    t = 4'd0;
      4'd1:    t = 4'd3;
      4'd2:    t = 4'd6;
      4'd3:    t = 4'd1;
      4'd4:    t = 4'd4;
      4'd5:    t = 4'd7;
      4'd6:    t = 4'd2;
      4'd7:    t = 4'd5;
      4'd8:    t = 4'd8;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

endpackage

### hdl/rtc_cell.sv
`include "rigid_transform_chain_macros.svh"

module rtc_cell import rtc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  link_t             link_i,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_slot_i,
  input  coord_t            wr_value_i,
  output link_t             link_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SUB  = 3'b010,
    S_MUL  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic                    dir_q;
  logic                    flag_q;
  coord_t                  coef_q [COEF_NUM];
  coord_t                  op_q [3];
  coord_t                  q_q [3];
  logic signed [PROD_W-1:0] prod_q, prod_d;
  acc_t                    acc_q, acc_sum, term, base;
  logic [CNT_W-1:0]        step_m1;
  logic [SLOT_W-1:0]       mul_idx;
  sat_t                    acc_sat;
  sat_t                    diff_sat [3];
  logic                    diff_ovf;

  // multiplier operands for the current step
  assign step_m1 = cnt_q - CNT_W'(1);
  assign mul_idx = dir_q ? tr_idx(cnt_q) : cnt_q;
  assign prod_d  = coef_q[mul_idx] * op_q[col_of(cnt_q)];

  // accumulate the registered product of the previous step
  assign term    = ACC_W'($signed(prod_q[PROD_W-1:FRAC_BITS]));
  assign base    = dir_q ? '0
                 : ACC_W'(coef_q[SLOT_W'(T_BASE) + SLOT_W'(row_of(step_m1))]);
  assign acc_sum = ((col_of(step_m1) == 2'd0) ? base : acc_q) + term;
  assign acc_sat = sat_coord(acc_sum);

  // inverse pre-subtract of the translation
  always_comb begin
    diff_ovf = 1'b0;
    for (int k = 0; k < 3; k++) begin
      diff_sat[k] = sat_coord(ACC_W'(op_q[k]) - ACC_W'(coef_q[T_BASE + k]));
      diff_ovf    = diff_ovf | diff_sat[k].ovf;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d   = '0;
          state_d = link_i.dir ? S_SUB : S_MUL;
        end
      end
      S_SUB: begin
        cnt_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (cnt_q == CNT_W'(LAST_STEP)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      coef_q[wr_slot_i] <= wr_value_i;
    end
    if (state_q == S_IDLE && start_i) begin
      dir_q  <= link_i.dir;
      flag_q <= link_i.flag;
      for (int k = 0; k < 3; k++) begin
        op_q[k] <= link_i.pt[k];
      end
    end
    if (state_q == S_SUB) begin
      for (int k = 0; k < 3; k++) begin
        op_q[k] <= diff_sat[k].val;
      end
      flag_q <= flag_q | diff_ovf;
    end
    if (state_q == S_MUL) begin
      if (cnt_q != CNT_W'(LAST_STEP)) begin
        prod_q <= prod_d;
      end
      if (cnt_q != '0) begin
        acc_q <= acc_sum;
        if (col_of(step_m1) == 2'd2) begin
          q_q[row_of(step_m1)] <= acc_sat.val;
          flag_q               <= flag_q | acc_sat.ovf;
        end
      end
    end
  end

  // hand-off to the neighbor
  assign link_o.valid = done_q;
  assign link_o.dir   = dir_q;
  assign link_o.flag  = flag_q;
  assign link_o.pt    = {q_q[2], q_q[1], q_q[0]};

  `RTC_ASSERT(a_start_idle, start_i |-> state_q == S_IDLE, "cell started while busy")
  `RTC_ASSERT(a_cnt_range, cnt_q <= CNT_W'(LAST_STEP), "step counter out of range")
  `RTC_ASSERT(a_done_after_mul, done_q |-> $past(state_q == S_MUL), "done without product pass")

endmodule

### hdl/rigid_transform_chain.sv
// channel   | handshake                    | payload
// ----------+------------------------------+----------------------------------------------
// request   | in_valid_i / in_stall_o      | operation, stage_slot, coefficient_*, point_*
// result    | out_valid_o / out_stall_i    | result_x/y/z, saturated, empty_chain
// config    | cfg_wr_en_i                  | cfg_wr_data_i (stages_in_use)
//
// each stage is one cell with a single 32x32 multiplier issuing nine products in turn:
// an inverse stage first pre-subtracts the translation; a forward stage adds it
// a transform request with n stages passes through all n cells before its result shows
// one transform is in flight at a time; write requests are accepted when not busy
// reset clears control and stages_in_use; coefficients are undefined until written
// a transform is stalled while the result register holds an untaken result

`include "rigid_transform_chain_macros.svh"

module rigid_transform_chain import rtc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [CFG_W-1:0]   cfg_wr_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [STAGE_W-1:0] stage_slot_i,
  input  logic [SLOT_W-1:0]  coefficient_slot_i,
  input  coord_t             coefficient_value_i,
  input  coord_t             point_x_i,
  input  coord_t             point_y_i,
  input  coord_t             point_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output coord_t             result_x_o,
  output coord_t             result_y_o,
  output coord_t             result_z_o,
  output logic               saturated_o,
  output logic               empty_chain_o
);

  logic [CFG_W-1:0]  cfg_q;
  logic [CFG_W-1:0]  n_eff;
  logic              busy_q, dir_q;
  logic [IDX_W-1:0]  end_idx_q, tgt_idx, last_idx;
  logic              is_xform, out_free, accept, launch, empty_load, done;
  logic              out_valid_q;
  coord_t            res_x_q, res_y_q, res_z_q;
  logic              sat_q, empty_q;
  link_t             launch_link, end_link;
  link_t             cell_out [MAX_STAGES];
  link_t             cell_in  [MAX_STAGES];
  logic [MAX_STAGES-1:0] cell_start, cell_wr, done_vec;

  // request decode
  assign n_eff      = (cfg_q > CFG_W'(MAX_STAGES)) ? CFG_W'(MAX_STAGES) : cfg_q;
  assign last_idx   = IDX_W'(n_eff - CFG_W'(1));
  assign is_xform   = (operation_i == OP_FWD) || (operation_i == OP_INV);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || (is_xform && !out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign launch     = accept && is_xform && (n_eff != '0);
  assign empty_load = accept && is_xform && (n_eff == '0);
  assign tgt_idx    = (operation_i == OP_INV) ? last_idx : '0;

  assign launch_link.valid = 1'b1;
  assign launch_link.dir   = (operation_i == OP_INV);
  assign launch_link.flag  = 1'b0;
  assign launch_link.pt    = {point_z_i, point_y_i, point_x_i};

  // chain of cells; the point walks up for forward and down for inverse
  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
    logic from_lo, from_hi;
    link_t lo_link, hi_link;

    if (i > 0) begin : g_lo
      assign lo_link = cell_out[i-1];
      assign from_lo = busy_q && !dir_q && cell_out[i-1].valid
                       && (end_idx_q != IDX_W'(i-1));
    end else begin : g_lo0
      assign lo_link = launch_link;
      assign from_lo = 1'b0;
    end

    if (i < MAX_STAGES-1) begin : g_hi
      assign hi_link = cell_out[i+1];
      assign from_hi = busy_q && dir_q && cell_out[i+1].valid
                       && (end_idx_q != IDX_W'(i+1));
    end else begin : g_hi0
      assign hi_link = launch_link;
      assign from_hi = 1'b0;
    end

    assign cell_start[i] = (launch && (tgt_idx == IDX_W'(i))) || from_lo || from_hi;
    assign cell_in[i]    = launch ? launch_link : (dir_q ? hi_link : lo_link);
    assign cell_wr[i]    = accept && (operation_i == OP_WRITE)
                           && (coefficient_slot_i < SLOT_W'(COEF_NUM))
                           && (stage_slot_i == STAGE_W'(i));
    assign done_vec[i]   = cell_out[i].valid;

    rtc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cell_start[i]),
      .link_i     (cell_in[i]),
      .wr_en_i    (cell_wr[i]),
      .wr_slot_i  (coefficient_slot_i),
      .wr_value_i (coefficient_value_i),
      .link_o     (cell_out[i])
    );
  end

  // result from the last cell of the walk
  assign end_link = cell_out[end_idx_q];
  assign done     = busy_q && end_link.valid;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        cfg_q <= cfg_wr_data_i;
      end
      if (launch) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done || empty_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk direction, end cell and result register
  always_ff @(posedge clk_i) begin
    if (launch) begin
      dir_q     <= (operation_i == OP_INV);
      end_idx_q <= (operation_i == OP_INV) ? '0 : last_idx;
    end
    if (done) begin
      res_x_q <= end_link.pt[0];
      res_y_q <= end_link.pt[1];
      res_z_q <= end_link.pt[2];
      sat_q   <= end_link.flag;
      empty_q <= 1'b0;
    end else if (empty_load) begin
      res_x_q <= point_x_i;
      res_y_q <= point_y_i;
      res_z_q <= point_z_i;
      sat_q   <= 1'b0;
      empty_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_x_o    = res_x_q;
  assign result_y_o    = res_y_q;
  assign result_z_o    = res_z_q;
  assign saturated_o   = sat_q;
  assign empty_chain_o = empty_q;

  `RTC_ASSERT(a_one_cell_done, $onehot0(done_vec), "more than one cell finished at once")
  `RTC_ASSERT(a_done_only_busy, !busy_q |-> done_vec == '0, "cell finished with no transform")
  `RTC_ASSERT(a_done_to_out, done |=> out_valid_q && !busy_q, "finished point not captured")

endmodule

### tb/tb_rigid_transform_chain.sv
`timescale 1ns / 100ps

module tb_rigid_transform_chain;
  import rtc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 12 * MAX_STAGES + 20;
  localparam int TABLE_DEPTH = MAX_STAGES * COEF_NUM;

  typedef enum int {ROW_ITEM, ROW_CFG, ROW_LOAD} row_kind_e;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
    logic   empty;
  } point_res_t;

  typedef struct {
    row_kind_e          kind;
    op_e                op;
    logic [STAGE_W-1:0] stage;
    logic [SLOT_W-1:0]  slot;
    coord_t             coef;
    coord_t             px;
    coord_t             py;
    coord_t             pz;
    bit                 typed;
    point_res_t         want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_wr_en_i = 1'b0;
  logic [CFG_W-1:0]   cfg_wr_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i = '0;
  logic [STAGE_W-1:0] stage_slot_i = '0;
  logic [SLOT_W-1:0]  coefficient_slot_i = '0;
  coord_t             coefficient_value_i = '0;
  coord_t             point_x_i = '0;
  coord_t             point_y_i = '0;
  coord_t             point_z_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  coord_t             result_x_o;
  coord_t             result_y_o;
  coord_t             result_z_o;
  logic               saturated_o;
  logic               empty_chain_o;

  rigid_transform_chain dut (.*);

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // model state
  coord_t           coef_table [TABLE_DEPTH];
  logic [CFG_W-1:0] chain_len;
  point_res_t       pending_points [$];
  int               mismatches = 0;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               cycles = 0;

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  // saturate to a coordinate and flag it
  function automatic coord_t clamp_coord(longint v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return 32'sh80000000;
    end
    return coord_t'(v);
  endfunction

  function automatic longint mul_q(coord_t a, coord_t b);
    longint pr;
    pr = longint'(a) * longint'(b);
    return pr >>> FRAC_BITS;
  endfunction

  // expected output of one transform request
  function automatic point_res_t transform_point(op_e op, coord_t px, coord_t py,
                                                 coord_t pz);
    point_res_t res;
    coord_t p [3];
    coord_t q [3];
    coord_t d [3];
    longint acc;
    bit f;
    int n;
    int s;
    f = 1'b0;
    n = (chain_len > MAX_STAGES) ? MAX_STAGES : chain_len;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int i = 0; i < n; i++) begin
      if (op == OP_FWD) begin
        s = i * COEF_NUM;
        for (int r = 0; r < 3; r++) begin
          acc = longint'(coef_table[s + T_BASE + r]);
          for (int k = 0; k < 3; k++) acc += mul_q(coef_table[s + r * 3 + k], p[k]);
          q[r] = clamp_coord(acc, f);
        end
      end else begin
        s = (n - 1 - i) * COEF_NUM;
        for (int k = 0; k < 3; k++)
          d[k] = clamp_coord(longint'(p[k]) - longint'(coef_table[s + T_BASE + k]), f);
        for (int r = 0; r < 3; r++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += mul_q(coef_table[s + k * 3 + r], d[k]);
          q[r] = clamp_coord(acc, f);
        end
      end
      p = q;
    end
    res.x = p[0];
    res.y = p[1];
    res.z = p[2];
    res.sat = f;
    res.empty = (n == 0);
    return res;
  endfunction

  // one request through the handshake, then update the model
  task automatic send_request(op_e op, logic [STAGE_W-1:0] st, logic [SLOT_W-1:0] sl,
                              coord_t cv, coord_t px, coord_t py, coord_t pz,
                              bit typed = 1'b0, point_res_t want = '{default: '0});
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    stage_slot_i <= st;
    coefficient_slot_i <= sl;
    coefficient_value_i <= cv;
    point_x_i <= px;
    point_y_i <= py;
    point_z_i <= pz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (op)
      OP_WRITE: if (sl < COEF_NUM) coef_table[st * COEF_NUM + sl] = cv;
      OP_FWD, OP_INV: pending_points.insert(pending_points.size(),
                                            typed ? want : transform_point(op, px, py, pz));
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_chain_len(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    chain_len = v;
  endtask

  function automatic coord_t near_unit();
    int v;
    if ($urandom_range(0, 9) == 0) return coord_t'($urandom);
    v = int'($urandom_range(0, 131072)) - 65536;
    return coord_t'(v);
  endfunction

  function automatic coord_t rand_point();
    int v;
    if ($urandom_range(0, 4) == 0) return coord_t'($urandom);
    v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    return coord_t'(v);
  endfunction

  // fill every coefficient of every stage
  task automatic load_chain();
    for (int s = 0; s < MAX_STAGES; s++)
      for (int c = 0; c < COEF_NUM; c++)
        send_request(OP_WRITE, s[STAGE_W-1:0], c[SLOT_W-1:0],
                     (c < T_BASE) ? near_unit() : rand_point(), '0, '0, '0);
  endtask

  task automatic set_phase(int k);
    case (k % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 59; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 59; end
      default: begin idle_pct = 26; stall_pct = 26; end
    endcase
  endtask

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    point_res_t w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_points.size() == 0) begin
          report("unexpected result", result_x_o, 0);
        end else begin
          w = pending_points.pop_front();
          if (result_x_o !== w.x) report("result_x", result_x_o, w.x);
          if (result_y_o !== w.y) report("result_y", result_y_o, w.y);
          if (result_z_o !== w.z) report("result_z", result_z_o, w.z);
          if (saturated_o !== w.sat) report("saturated", saturated_o, w.sat);
          if (empty_chain_o !== w.empty) report("empty_chain", empty_chain_o, w.empty);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  localparam coord_t PMAX = 32'sh7fffffff;
  localparam coord_t PMIN = 32'sh80000000;
  localparam point_res_t SAT_HI = '{PMAX, PMAX, PMAX, 1'b1, 1'b0};

  stim_row_t directed [] = '{
    // empty chain after reset passes points through
    '{ROW_ITEM, OP_FWD, 0, 0, 0, PMAX, PMIN, 0, 1, '{PMAX, PMIN, 0, 1'b0, 1'b1}},
    '{ROW_ITEM, OP_INV, 0, 0, 0, PMIN, -1, PMAX, 1, '{PMIN, -1, PMAX, 1'b0, 1'b1}},
    '{ROW_ITEM, OP_NONE, 7, 15, PMAX, PMAX, PMAX, PMAX, 0, '{default: '0}},
    '{ROW_LOAD, OP_WRITE, 0, 0, 0, 0, 0, 0, 0, '{default: '0}},
    '{ROW_CFG, OP_WRITE, 0, 0, 1, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_FWD, 0, 0, 0, 32'sh10000, -32'sh20000, 32'sh30000, 0, '{default: '0}},
    '{ROW_ITEM, OP_INV, 0, 0, 0, PMIN, PMAX, 0, 0, '{default: '0}},
    // largest coefficients drive every sum into saturation
    '{ROW_ITEM, OP_WRITE, 0, 0, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 1, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 2, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 3, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 4, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 5, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 6, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 7, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 8, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 9, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 10, PMAX, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 11, PMAX, 0, 0, 0, 0, '{default: '0}},
    // slots past the translation are dropped
    '{ROW_ITEM, OP_WRITE, 0, 12, 0, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_WRITE, 0, 15, 0, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_FWD, 0, 0, 0, PMAX, PMAX, PMAX, 1, SAT_HI},
    '{ROW_ITEM, OP_INV, 0, 0, 0, PMIN, PMIN, PMIN, 0, '{default: '0}},
    '{ROW_CFG, OP_WRITE, 0, 0, 8, 0, 0, 0, 0, '{default: '0}},
    '{ROW_ITEM, OP_INV, 0, 0, 0, PMAX, 0, PMIN, 0, '{default: '0}}
  };

  logic [CFG_W-1:0] chain_plan [] = '{0, 15, 1, 9, 8, 2, 5, 3};

  initial begin
    int r;
    int waited;
    chain_len = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      case (directed[i].kind)
        ROW_CFG:  set_chain_len(directed[i].coef[CFG_W-1:0]);
        ROW_LOAD: load_chain();
        default:  send_request(directed[i].op, directed[i].stage, directed[i].slot,
                               directed[i].coef, directed[i].px, directed[i].py,
                               directed[i].pz, directed[i].typed, directed[i].want);
      endcase
    end

    // random part, several chain lengths and handshake phases
    for (int ph = 0; ph < 16; ph++) begin
      set_phase(ph);
      if (ph % 8 == 0) load_chain();
      set_chain_len((ph < 8) ? chain_plan[ph] : CFG_W'($urandom_range(0, 15)));
      for (int i = 0; i < 14; i++) begin
        r = $urandom_range(0, 19);
        if (r < 14)
          send_request((r < 7) ? OP_FWD : OP_INV, '0, '0, '0,
                       rand_point(), rand_point(), rand_point());
        else if (r < 18)
          send_request(OP_WRITE, STAGE_W'($urandom), SLOT_W'($urandom_range(0, 13)),
                       ($urandom_range(0, 1)) ? near_unit() : coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        else
          send_request(OP_NONE, STAGE_W'($urandom), SLOT_W'($urandom), coord_t'($urandom),
                       coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        // sender holds off until the chain has drained
        if (ph == 5 && i == 10) begin
          in_valid_i <= 1'b0;
          while (pending_points.size() != 0) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_points.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_points.size() != 0) report("results missing", pending_points.size(), 0);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
